// ----- rtl/gaar_pkg.sv -----
package gaar_pkg;

  // parameter defaults
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int COEFF_FRACTION_BITS_DEF = 15;

  // fixed result width
  localparam int OUT_W = 16;

  // status codes of a result item
  localparam logic [1:0] STAT_SAMPLE  = 2'd0;
  localparam logic [1:0] STAT_REF_OK  = 2'd1;
  localparam logic [1:0] STAT_REF_REJ = 2'd2;

  // ratio jobs of a calibration, in the order they are run
  localparam int JOB_W = 3;
  localparam logic [JOB_W-1:0] JOB_CY = 3'd0;  // x^2 / r^2
  localparam logic [JOB_W-1:0] JOB_SY = 3'd1;  // y^2 / r^2
  localparam logic [JOB_W-1:0] JOB_CP = 3'd2;  // z^2 / g^2
  localparam logic [JOB_W-1:0] JOB_SP = 3'd3;  // r^2 / g^2
  localparam logic [JOB_W-1:0] JOB_XG = 3'd4;  // x^2 / g^2
  localparam logic [JOB_W-1:0] JOB_YG = 3'd5;  // y^2 / g^2
  localparam int NUM_JOBS = 6;

  // commands from the controller to the datapath
  typedef struct packed {
    logic             load_in;
    logic             mac_en;
    logic             mac_first;
    logic [1:0]       col;
    logic             sq_en;
    logic             sum_en;
    logic             div_init;
    logic             div_step;
    logic             div_first;
    logic             sqrt_step;
    logic             ratio_wr;
    logic [JOB_W-1:0] job;
    logic             prod_en;
    logic             coef_wr;
    logic             out_load;
    logic [1:0]       out_code;
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic is_sample;
    logic xy_zero;
    logic out_busy;
  } stat_t;

endpackage

// ----- rtl/gaar_ctrl.sv -----
module gaar_ctrl #(
  parameter int COEFF_FRACTION_BITS = gaar_pkg::COEFF_FRACTION_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  gaar_pkg::stat_t  stat,
  output gaar_pkg::cmd_t   cmd
);

  localparam int F  = COEFF_FRACTION_BITS;
  localparam int CW = $clog2(2 * F + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DISP = 4'd1;
  localparam logic [3:0] S_MAC  = 4'd2;
  localparam logic [3:0] S_ROUT = 4'd3;
  localparam logic [3:0] S_SQ   = 4'd4;
  localparam logic [3:0] S_SUM  = 4'd5;
  localparam logic [3:0] S_DIVI = 4'd6;
  localparam logic [3:0] S_DIV  = 4'd7;
  localparam logic [3:0] S_SQRT = 4'd8;
  localparam logic [3:0] S_RWR  = 4'd9;
  localparam logic [3:0] S_PROD = 4'd10;
  localparam logic [3:0] S_CWR  = 4'd11;

  logic [3:0]                 state_r, state_nxt;
  logic [CW-1:0]              cnt_r, cnt_nxt;
  logic [gaar_pkg::JOB_W-1:0] job_r, job_nxt;

  // state, step counter and job counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      job_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      job_r   <= job_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE) || stat.out_busy;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    job_nxt   = job_r;
    cmd       = '0;
    cmd.col   = cnt_r[1:0];
    cmd.job   = job_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid && !stat.out_busy) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_DISP;
        end
      end
      S_DISP: begin
        cnt_nxt = '0;
        job_nxt = gaar_pkg::JOB_CY;
        if (stat.is_sample) begin
          state_nxt = S_MAC;
        end else if (stat.xy_zero) begin
          cmd.out_load = 1'b1;
          cmd.out_code = gaar_pkg::STAT_REF_REJ;
          state_nxt    = S_IDLE;
        end else begin
          state_nxt = S_SQ;
        end
      end
      S_MAC: begin
        cmd.mac_en    = 1'b1;
        cmd.mac_first = (cnt_r == '0);
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == CW'(2)) begin
          state_nxt = S_ROUT;
        end
      end
      S_ROUT: begin
        cmd.out_load = 1'b1;
        cmd.out_code = gaar_pkg::STAT_SAMPLE;
        state_nxt    = S_IDLE;
      end
      S_SQ: begin
        cmd.sq_en = 1'b1;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.sum_en = 1'b1;
        state_nxt  = S_DIVI;
      end
      S_DIVI: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step  = 1'b1;
        cmd.div_first = (cnt_r == '0);
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == CW'(2 * F)) begin
          cnt_nxt   = '0;
          state_nxt = S_SQRT;
        end
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == CW'(F)) begin
          state_nxt = S_RWR;
        end
      end
      S_RWR: begin
        cmd.ratio_wr = 1'b1;
        if (job_r == gaar_pkg::JOB_YG) begin
          state_nxt = S_PROD;
        end else begin
          job_nxt   = job_r + 1'b1;
          state_nxt = S_DIVI;
        end
      end
      S_PROD: begin
        cmd.prod_en = 1'b1;
        state_nxt   = S_CWR;
      end
      S_CWR: begin
        cmd.coef_wr  = 1'b1;
        cmd.out_load = 1'b1;
        cmd.out_code = gaar_pkg::STAT_REF_OK;
        state_nxt    = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/gaar_datapath.sv -----
module gaar_datapath #(
  parameter int SAMPLE_WIDTH        = gaar_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEFF_FRACTION_BITS = gaar_pkg::COEFF_FRACTION_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  gaar_pkg::cmd_t                    cmd,
  output gaar_pkg::stat_t                   stat,
  input  logic                              in_kind,
  input  logic signed [SAMPLE_WIDTH-1:0]    in_accel_x,
  input  logic signed [SAMPLE_WIDTH-1:0]    in_accel_y,
  input  logic signed [SAMPLE_WIDTH-1:0]    in_accel_z,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [gaar_pkg::OUT_W-1:0] out_longitudinal,
  output logic signed [gaar_pkg::OUT_W-1:0] out_lateral,
  output logic signed [gaar_pkg::OUT_W-1:0] out_vertical,
  output logic [1:0]                        out_status
);

  localparam int SW = SAMPLE_WIDTH;
  localparam int F  = COEFF_FRACTION_BITS;
  localparam int MW = ((SW > F) ? SW : F) + 2;   // multiplier operand width
  localparam int AW = F + SW + 3;                 // row accumulator width
  localparam int DW = 2 * SW + 2;                 // divisor width (g^2)
  localparam int QW = 2 * F + 2;                  // quotient width, even
  localparam int OW = gaar_pkg::OUT_W;
  localparam logic [F:0] CMAX = {1'b0, {F{1'b1}}};

  // clamp a magnitude to the largest coefficient and apply the sign
  function automatic logic signed [F:0] mk_coef(input logic [F:0] m, input logic neg);
    logic [F:0] mc;
    mc = (m > CMAX) ? CMAX : m;
    return neg ? -$signed(mc) : $signed(mc);
  endfunction

  // magnitude of a sample
  function automatic logic [SW-1:0] mag(input logic signed [SW-1:0] v);
    return v[SW-1] ? SW'(-v) : SW'(v);
  endfunction

  logic                    kind_r;
  logic signed [SW-1:0]    smp_r [3];
  logic signed [F:0]       coef_r [3][3];
  logic signed [AW-1:0]    acc_r [3];
  logic [2*SW-1:0]         sq_r [3];
  logic [2*SW:0]           r2_r;
  logic [DW-1:0]           g2_r;
  logic [DW-1:0]           drem_r;
  logic [QW-1:0]           q_r;
  logic [F+1:0]            srem_r;
  logic [F:0]              root_r;
  logic [F:0]              ratio_r [gaar_pkg::NUM_JOBS];
  logic [F:0]              mr_r [2];
  logic                    out_valid_r;
  logic signed [OW-1:0]    lon_r, lat_r, ver_r;
  logic [1:0]              status_r;

  logic signed [MW-1:0]    ma [3];
  logic signed [MW-1:0]    mb [3];
  logic signed [2*MW-1:0]  mp [3];
  logic signed [SW-1:0]    col_smp;
  logic [DW-1:0]           n2, d2;
  logic [DW:0]             dcand;
  logic                    dge;
  logic [F+3:0]            srem2, strial;
  logic                    sge;
  logic signed [OW-1:0]    rot [3];
  logic [2*F+1:0]          mrs [2];

  // status to the controller
  assign stat.is_sample = kind_r;
  assign stat.xy_zero   = (smp_r[0] == '0) && (smp_r[1] == '0);
  assign stat.out_busy  = out_valid_r && out_stall;

  // multiplier bank operand select
  always_comb begin
    case (cmd.col)
      2'd0:    col_smp = smp_r[0];
      2'd1:    col_smp = smp_r[1];
      default: col_smp = smp_r[2];
    endcase
    for (int i = 0; i < 3; i++) begin
      ma[i] = MW'(coef_r[i][cmd.col]);
      mb[i] = MW'(col_smp);
    end
    if (cmd.sq_en) begin
      for (int i = 0; i < 3; i++) begin
        ma[i] = $signed(MW'(mag(smp_r[i])));
        mb[i] = $signed(MW'(mag(smp_r[i])));
      end
    end else if (cmd.prod_en) begin
      ma[0] = $signed(MW'(ratio_r[gaar_pkg::JOB_CP]));
      mb[0] = $signed(MW'(ratio_r[gaar_pkg::JOB_CY]));
      ma[1] = $signed(MW'(ratio_r[gaar_pkg::JOB_CP]));
      mb[1] = $signed(MW'(ratio_r[gaar_pkg::JOB_SY]));
    end
    for (int i = 0; i < 3; i++) begin
      mp[i] = ma[i] * mb[i];
    end
    for (int k = 0; k < 2; k++) begin
      mrs[k] = mp[k][2*F+1:0] + (QW'(1) << (F - 1));
    end
  end

  // divider operand select
  always_comb begin
    case (cmd.job)
      gaar_pkg::JOB_CY, gaar_pkg::JOB_XG: n2 = DW'(sq_r[0]);
      gaar_pkg::JOB_SY, gaar_pkg::JOB_YG: n2 = DW'(sq_r[1]);
      gaar_pkg::JOB_CP:                   n2 = DW'(sq_r[2]);
      default:                            n2 = DW'(r2_r);
    endcase
    d2 = ((cmd.job == gaar_pkg::JOB_CY) || (cmd.job == gaar_pkg::JOB_SY)) ?
         DW'(r2_r) : g2_r;
    dcand  = cmd.div_first ? {1'b0, drem_r} : {drem_r, 1'b0};
    dge    = dcand >= {1'b0, d2};
    srem2  = {srem_r, q_r[QW-1:QW-2]};
    strial = {1'b0, root_r, 2'b01};
    sge    = srem2 >= strial;
  end

  // rounding and saturation of the three rows
  always_comb begin
    logic             neg;
    logic [AW-1:0]    m;
    logic [AW:0]      rq;
    for (int i = 0; i < 3; i++) begin
      neg = acc_r[i][AW-1];
      m   = neg ? AW'(-acc_r[i]) : AW'(acc_r[i]);
      rq  = ({1'b0, m} + ((AW + 1)'(1) << (F - 1))) >> F;
      if (neg) begin
        rot[i] = (rq > (AW + 1)'(32768)) ? {1'b1, {(OW - 1){1'b0}}} : -$signed(rq[OW-1:0]);
      end else begin
        rot[i] = (rq > (AW + 1)'(32767)) ? {1'b0, {(OW - 1){1'b1}}} : $signed(rq[OW-1:0]);
      end
    end
  end

  // input capture and arithmetic registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      kind_r   <= in_kind;
      smp_r[0] <= in_accel_x;
      smp_r[1] <= in_accel_y;
      smp_r[2] <= in_accel_z;
    end
    if (cmd.mac_en) begin
      for (int i = 0; i < 3; i++) begin
        acc_r[i] <= (cmd.mac_first ? AW'(0) : acc_r[i]) + AW'(mp[i]);
      end
    end
    if (cmd.sq_en) begin
      for (int i = 0; i < 3; i++) begin
        sq_r[i] <= mp[i][2*SW-1:0];
      end
    end
    if (cmd.sum_en) begin
      r2_r <= {1'b0, sq_r[0]} + {1'b0, sq_r[1]};
      g2_r <= DW'(sq_r[0]) + DW'(sq_r[1]) + DW'(sq_r[2]);
    end
    if (cmd.div_init) begin
      drem_r <= n2;
      q_r    <= '0;
      srem_r <= '0;
      root_r <= '0;
    end
    if (cmd.div_step) begin
      drem_r <= dge ? DW'(dcand - {1'b0, d2}) : DW'(dcand);
      q_r    <= {q_r[QW-2:0], dge};
    end
    if (cmd.sqrt_step) begin
      srem_r <= sge ? (F + 2)'(srem2 - strial) : (F + 2)'(srem2);
      root_r <= {root_r[F-1:0], sge};
      q_r    <= {q_r[QW-3:0], 2'b00};
    end
    if (cmd.ratio_wr) begin
      ratio_r[cmd.job] <= root_r;
    end
    if (cmd.prod_en) begin
      for (int k = 0; k < 2; k++) begin
        mr_r[k] <= mrs[k][2*F:F];
      end
    end
  end

  // rotation matrix, zero after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          coef_r[i][j] <= '0;
        end
      end
    end else if (cmd.coef_wr) begin
      coef_r[0][0] <= mk_coef(mr_r[0], smp_r[2][SW-1] != smp_r[0][SW-1]);
      coef_r[0][1] <= mk_coef(mr_r[1], smp_r[2][SW-1] == smp_r[1][SW-1]);
      coef_r[0][2] <= mk_coef(ratio_r[gaar_pkg::JOB_SP], 1'b1);
      coef_r[1][0] <= mk_coef(ratio_r[gaar_pkg::JOB_SY], smp_r[1][SW-1]);
      coef_r[1][1] <= mk_coef(ratio_r[gaar_pkg::JOB_CY], smp_r[0][SW-1]);
      coef_r[1][2] <= '0;
      coef_r[2][0] <= mk_coef(ratio_r[gaar_pkg::JOB_XG], smp_r[0][SW-1]);
      coef_r[2][1] <= mk_coef(ratio_r[gaar_pkg::JOB_YG], !smp_r[1][SW-1]);
      coef_r[2][2] <= mk_coef(ratio_r[gaar_pkg::JOB_CP], smp_r[2][SW-1]);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status_r <= cmd.out_code;
      if (cmd.out_code == gaar_pkg::STAT_SAMPLE) begin
        lon_r <= rot[0];
        lat_r <= rot[1];
        ver_r <= rot[2];
      end else begin
        lon_r <= '0;
        lat_r <= '0;
        ver_r <= '0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_longitudinal = lon_r;
  assign out_lateral      = lat_r;
  assign out_vertical     = ver_r;
  assign out_status       = status_r;

endmodule

// ----- rtl/gravity_aligned_axis_rotation.sv -----
// channel   ports                                            direction
// in        in_valid, in_stall, in_kind, in_accel_x/y/z      item in
// out       out_valid, out_stall, out_longitudinal,
//           out_lateral, out_vertical, out_status            item out
//
// a sample item passes through accept, dispatch, three multiply-accumulate
// steps on three shared multipliers, then rounding into the output register.
// a reference item runs the bit-serial divider and square root once for each
// of six ratios.
// reset clears the rotation matrix to zero and empties the output register.
// a stalled result holds; no new item is taken until it is free or emptying.
module gravity_aligned_axis_rotation #(
  parameter int SAMPLE_WIDTH        = gaar_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEFF_FRACTION_BITS = gaar_pkg::COEFF_FRACTION_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_kind,
  input  logic signed [SAMPLE_WIDTH-1:0]    in_accel_x,
  input  logic signed [SAMPLE_WIDTH-1:0]    in_accel_y,
  input  logic signed [SAMPLE_WIDTH-1:0]    in_accel_z,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [gaar_pkg::OUT_W-1:0] out_longitudinal,
  output logic signed [gaar_pkg::OUT_W-1:0] out_lateral,
  output logic signed [gaar_pkg::OUT_W-1:0] out_vertical,
  output logic [1:0]                        out_status
);

  gaar_pkg::cmd_t  cmd;
  gaar_pkg::stat_t stat;

  // sequencing
  gaar_ctrl #(
    .COEFF_FRACTION_BITS(COEFF_FRACTION_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // arithmetic and storage
  gaar_datapath #(
    .SAMPLE_WIDTH        (SAMPLE_WIDTH),
    .COEFF_FRACTION_BITS (COEFF_FRACTION_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_kind          (in_kind),
    .in_accel_x       (in_accel_x),
    .in_accel_y       (in_accel_y),
    .in_accel_z       (in_accel_z),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_longitudinal (out_longitudinal),
    .out_lateral      (out_lateral),
    .out_vertical     (out_vertical),
    .out_status       (out_status)
  );

endmodule

// ----- sim/tb_gravity_aligned_axis_rotation.sv -----
module tb_gravity_aligned_axis_rotation;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int F = gaar_pkg::COEFF_FRACTION_BITS_DEF;
  localparam longint CMAX = (64'sd1 <<< F) - 1;
  localparam int N_DIRECTED = 20;
  localparam int N_RANDOM = 500;

  // dut ports
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_kind = 1'b0;
  logic signed [15:0] in_accel_x = '0;
  logic signed [15:0] in_accel_y = '0;
  logic signed [15:0] in_accel_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] out_longitudinal, out_lateral, out_vertical;
  logic [1:0] out_status;

  typedef struct packed {
    logic signed [15:0] lon;
    logic signed [15:0] lat;
    logic signed [15:0] vert;
    logic [1:0]         status;
  } rot_result_t;

  typedef struct {
    logic               kind;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic               typed;
    rot_result_t        want;
  } stim_row_t;

  rot_result_t pending_results[$];
  longint matrix[9];
  int errors = 0;
  int n_ref = 0;
  int n_rej = 0;
  int n_samp = 0;
  bit quiet_tail = 1'b0;
  bit hold_out = 1'b0;
  bit done_stim = 1'b0;
  stim_row_t directed[N_DIRECTED];

  gravity_aligned_axis_rotation u_top (.*);

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // floor square root on 64 bits
  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned fx_ratio(longint unsigned n2, longint unsigned d2);
    return isqrt((n2 << (2 * F)) / d2);
  endfunction

  function automatic longint clamp_coeff(longint unsigned m, bit neg);
    longint v;
    v = (m > CMAX) ? CMAX : longint'(m);
    return neg ? -v : v;
  endfunction

  function automatic logic signed [15:0] rotate_row(int b, longint x, longint y, longint z);
    longint sum;
    longint unsigned m, q;
    sum = matrix[b] * x + matrix[b+1] * y + matrix[b+2] * z;
    m = (sum < 0) ? longint'(-sum) : sum;
    q = (m + (64'd1 << (F - 1))) >> F;
    if (sum < 0) return (q > 32768) ? -16'sd32768 : 16'(-longint'(q));
    return (q > 32767) ? 16'sd32767 : 16'(q);
  endfunction

  // orientation predictor: updates the matrix and returns the result item
  function automatic rot_result_t predict_orientation(logic kind, logic signed [15:0] sx,
                                                       logic signed [15:0] sy_in,
                                                       logic signed [15:0] sz);
    rot_result_t r;
    longint x, y, z;
    longint unsigned xm, ym, zm, r2, g2, cy, sy, cp, sp, xg, yg;
    bit xn, yn, zn;
    x = sx; y = sy_in; z = sz;
    r = '0;
    if (kind) begin
      r.lon = rotate_row(0, x, y, z);
      r.lat = rotate_row(3, x, y, z);
      r.vert = rotate_row(6, x, y, z);
      r.status = gaar_pkg::STAT_SAMPLE;
      return r;
    end
    if (x == 0 && y == 0) begin
      r.status = gaar_pkg::STAT_REF_REJ;
      return r;
    end
    xm = (x < 0) ? -x : x;
    ym = (y < 0) ? -y : y;
    zm = (z < 0) ? -z : z;
    r2 = xm * xm + ym * ym;
    g2 = r2 + zm * zm;
    cy = fx_ratio(xm * xm, r2);
    sy = fx_ratio(ym * ym, r2);
    cp = fx_ratio(zm * zm, g2);
    sp = fx_ratio(r2, g2);
    xg = fx_ratio(xm * xm, g2);
    yg = fx_ratio(ym * ym, g2);
    xn = x < 0; yn = y < 0; zn = z < 0;
    matrix[0] = clamp_coeff((cp * cy + (64'd1 << (F - 1))) >> F, zn != xn);
    matrix[1] = clamp_coeff((cp * sy + (64'd1 << (F - 1))) >> F, zn == yn);
    matrix[2] = clamp_coeff(sp, 1'b1);
    matrix[3] = clamp_coeff(sy, yn);
    matrix[4] = clamp_coeff(cy, xn);
    matrix[5] = 0;
    matrix[6] = clamp_coeff(xg, xn);
    matrix[7] = clamp_coeff(yg, !yn);
    matrix[8] = clamp_coeff(cp, zn);
    r.status = gaar_pkg::STAT_REF_OK;
    return r;
  endfunction

  function automatic stim_row_t mk(logic k, int x, int y, int z, logic typed = 1'b0,
                                   rot_result_t want = '0);
    stim_row_t s;
    s.kind = k; s.x = 16'(x); s.y = 16'(y); s.z = 16'(z);
    s.typed = typed; s.want = want;
    return s;
  endfunction

  // send one item, with random gaps before it
  task automatic send_item(stim_row_t s);
    rot_result_t p;
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= s.kind;
    in_accel_x <= s.x;
    in_accel_y <= s.y;
    in_accel_z <= s.z;
    p = predict_orientation(s.kind, s.x, s.y, s.z);
    if (s.typed && p !== s.want) begin
      $error("directed row disagrees with predictor: want %h got %h", s.want, p);
      errors++;
    end
    pending_results.push_back(s.typed ? s.want : p);
    if (s.kind) n_samp++;
    else if (p.status == gaar_pkg::STAT_REF_REJ) n_rej++;
    else n_ref++;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // stimulus
  initial begin
    stim_row_t s;
    int mode;
    foreach (matrix[i]) matrix[i] = 0;
    directed[0] = mk(1, 32767, -32768, 1000, 1, '{0, 0, 0, gaar_pkg::STAT_SAMPLE});
    directed[1] = mk(0, 0, 0, 16384, 1, '{0, 0, 0, gaar_pkg::STAT_REF_REJ});
    directed[2] = mk(1, -32768, 32767, -32768, 1, '{0, 0, 0, gaar_pkg::STAT_SAMPLE});
    directed[3] = mk(0, 0, 0, -32768, 1, '{0, 0, 0, gaar_pkg::STAT_REF_REJ});
    directed[4] = mk(0, 0, 0, 0, 1, '{0, 0, 0, gaar_pkg::STAT_REF_REJ});
    directed[5] = mk(0, 16384, 0, 0);
    directed[6] = mk(1, 16384, -1, 7);
    directed[7] = mk(0, 0, 100, 16000);
    directed[8] = mk(1, 32767, 32767, 32767);
    directed[9] = mk(0, -32768, -32768, -32768);
    directed[10] = mk(1, -32768, -32768, -32768);
    directed[11] = mk(0, 0, 0, 5);
    directed[12] = mk(1, 32767, 32767, 32767);
    directed[13] = mk(0, 32767, 32767, 32767);
    directed[14] = mk(1, -32768, 32767, 0);
    directed[15] = mk(0, 1, 0, -32768);
    directed[16] = mk(1, 100, 200, -32768);
    directed[17] = mk(0, -1, 1, 0);
    directed[18] = mk(1, 32767, -32768, -1);
    directed[19] = mk(0, 300, -200, 16000);
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed[i]) send_item(directed[i]);
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i > N_RANDOM - 60) quiet_tail = 1'b1;
      mode = $urandom_range(0, 99);
      if (mode < 12) begin
        // reference near gravity with random tilt
        s = mk(0, $signed($urandom_range(0, 8000)) - 4000,
               $signed($urandom_range(0, 8000)) - 4000,
               ($urandom_range(0, 1) ? 16000 : -16000));
      end else if (mode < 17) begin
        s = mk(0, $signed(16'($urandom)), $signed(16'($urandom)), $signed(16'($urandom)));
      end else if (mode < 19) begin
        s = mk(0, 0, 0, $signed(16'($urandom)));
      end else begin
        s = mk(1, $signed(16'($urandom)), $signed(16'($urandom)), $signed(16'($urandom)));
      end
      send_item(s);
    end
    in_valid <= 1'b0;
    done_stim = 1'b1;
  end

  // result receiver: random stall bursts, plus one long hold-off
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_out) out_stall <= 1'b1;
      else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        out_stall <= 1'b0;
      end else out_stall <= 1'b0;
    end
  end

  initial begin
    wait (n_samp > 60);
    @(posedge clk);
    hold_out = 1'b1;
    repeat (400) @(posedge clk);
    hold_out = 1'b0;
  end

  // result checking
  always @(posedge clk) begin
    rot_result_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result item");
        errors++;
      end else begin
        w = pending_results.pop_front();
        if (out_longitudinal !== w.lon) begin
          $error("longitudinal: expected %0d actual %0d", w.lon, out_longitudinal);
          errors++;
        end
        if (out_lateral !== w.lat) begin
          $error("lateral: expected %0d actual %0d", w.lat, out_lateral);
          errors++;
        end
        if (out_vertical !== w.vert) begin
          $error("vertical: expected %0d actual %0d", w.vert, out_vertical);
          errors++;
        end
        if (out_status !== w.status) begin
          $error("status: expected %0d actual %0d", w.status, out_status);
          errors++;
        end
      end
    end
  end

  // end of run
  initial begin
    wait (done_stim);
    wait (pending_results.size() == 0);
    repeat (20) @(posedge clk);
    $display("covered %0d samples, %0d accepted and %0d rejected references",
             n_samp, n_ref, n_rej);
    if (errors == 0 && pending_results.size() == 0)
      $display("tb_gravity_aligned_axis_rotation OK");
    else
      $display("tb_gravity_aligned_axis_rotation NOT OK");
    $finish;
  end

  // timeout
  initial begin
    #8ms;
    $display("tb_gravity_aligned_axis_rotation NOT OK");
    $finish;
  end
endmodule
